[sv/mmnt_pkg.sv]
// Shared types and constants for the monophonic MIDI note tracker.
// Holds message kinds, parse positions, action codes and payload widths.
// No dependencies.
package mmnt_pkg;

	// Payload widths
	localparam int unsigned ByteW   = 8;
	localparam int unsigned Data7W  = 7;
	localparam int unsigned TuneW   = 21;
	localparam int unsigned FracW   = 13;
	localparam int unsigned ActW    = 3;
	localparam int unsigned MTdataW = 40;

	// Key offsets: note-on tunes from key 38, pitch bend folds the centre
	// of 0x2000 into one more semitone below
	localparam logic [ByteW-1:0] BaseKey     = 8'd38;
	localparam logic [ByteW-1:0] BendBaseKey = 8'd39;

	// Controller numbers that raise panic
	localparam logic [Data7W-1:0] CcAllSoundOff = 7'h78;
	localparam logic [Data7W-1:0] CcAllNotesOff = 7'h7B;

	// Message kinds (high nibble of the status byte)
	typedef enum logic [3:0] {
		KIND_NOTE_OFF   = 4'h8,
		KIND_NOTE_ON    = 4'h9,
		KIND_POLY_TOUCH = 4'hA,
		KIND_CONTROL    = 4'hB,
		KIND_PROGRAM    = 4'hC,
		KIND_AFTERTOUCH = 4'hD,
		KIND_BEND       = 4'hE,
		KIND_SYSTEM     = 4'hF
	} kind_t;

	// Parser position within a message
	typedef enum logic [1:0] {
		POS_STATUS = 2'd0,
		POS_DATA1  = 2'd1,
		POS_DATA2  = 2'd2
	} pos_t;

	// Result action codes
	typedef enum logic [ActW-1:0] {
		ACT_NONE    = 3'd0,
		ACT_NOTE_ON = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_PANIC   = 3'd3,
		ACT_BEND    = 3'd4
	} act_t;

	// Configuration register indexes
	localparam logic REG_LEGATO = 1'b0;

	// One result beat
	typedef struct packed {
		logic [ActW-1:0]   action;
		logic              retrigger;
		logic [TuneW-1:0]  tuning;
		logic [Data7W-1:0] velocity;
		logic [Data7W-1:0] key;
	} result_t;

endpackage

[sv/midi_mono_note_tracker.sv]
// Monophonic last-note MIDI tracker: one result beat for every MIDI byte beat.
// Throughput: one byte per cycle while the skid register is empty; a
// two-entry output stage (result register plus skid register) keeps
// input open while one result waits.
// Reset (arst_n low): parser expects status, no note held, key, velocity
// and legato cleared, output stage empty.
module midi_mono_note_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	// Byte stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mmnt_pkg::ByteW-1:0]    s_tdata,   // [7:0] midi_byte
	input  logic                          s_tlast,   // end_of_block
	// Result stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mmnt_pkg::MTdataW-1:0]  m_tdata,   // [0] retrigger, [21:1] tuning,
	                                                 // [28:22] velocity, [35:29] key,
	                                                 // [39:36] zero
	output logic [mmnt_pkg::ActW-1:0]     m_tuser,   // [2:0] action
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Configuration and tracker state
	logic                               legato_q;
	mmnt_pkg::pos_t                     pos_q, pos_d;
	logic [3:0]                         kind_q, kind_d;
	logic [mmnt_pkg::Data7W-1:0]        first_q, first_d;
	logic [mmnt_pkg::Data7W-1:0]        key_q, key_d;
	logic                               held_vld_q, held_vld_d;
	logic [mmnt_pkg::Data7W-1:0]        held_key_q, held_key_d;
	logic [mmnt_pkg::Data7W-1:0]        vel_q, vel_d;

	// Output stage
	mmnt_pkg::result_t                  res_d, res_q, skid_q;
	logic                               res_vld_q, skid_vld_q;

	logic                               in_beat, out_beat;
	logic [mmnt_pkg::Data7W-1:0]        data7;
	logic signed [mmnt_pkg::ByteW-1:0]  note_semi, bend_semi;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign s_tready = !skid_vld_q;

	// Configuration: write legato, read it back
	assign pready = 1'b1;
	assign prdata = {31'd0, legato_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legato_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == mmnt_pkg::REG_LEGATO)) begin
			legato_q <= pwdata[0];
		end
	end

	// Parse one byte and work out the next state and the result
	assign data7     = s_tdata[mmnt_pkg::Data7W-1:0];
	assign note_semi = signed'({1'b0, first_q} - mmnt_pkg::BaseKey);
	assign bend_semi = signed'({1'b0, key_q} - mmnt_pkg::BendBaseKey);

	always_comb begin
		pos_d      = pos_q;
		kind_d     = kind_q;
		first_d    = first_q;
		key_d      = key_q;
		held_vld_d = held_vld_q;
		held_key_d = held_key_q;
		vel_d      = vel_q;
		res_d      = '0;
		res_d.action = mmnt_pkg::ACT_NONE;

		case (pos_q)
			mmnt_pkg::POS_STATUS: begin
				// Skip system bytes; take any other high nibble as a kind
				if (s_tdata[7:4] != mmnt_pkg::KIND_SYSTEM) begin
					kind_d = s_tdata[7:4];
					pos_d  = mmnt_pkg::POS_DATA1;
				end
			end
			mmnt_pkg::POS_DATA1: begin
				first_d = data7;
				if (kind_q inside {mmnt_pkg::KIND_PROGRAM, mmnt_pkg::KIND_AFTERTOUCH}) begin
					pos_d = mmnt_pkg::POS_STATUS;
				end else begin
					pos_d = mmnt_pkg::POS_DATA2;
				end
			end
			default: begin
				// Second data byte completes the message
				pos_d = mmnt_pkg::POS_STATUS;
				if (kind_q == mmnt_pkg::KIND_NOTE_ON && data7 != '0) begin
					key_d           = first_q;
					vel_d           = data7;
					held_vld_d      = 1'b1;
					held_key_d      = first_q;
					res_d.action    = mmnt_pkg::ACT_NOTE_ON;
					res_d.retrigger = !held_vld_q || !legato_q;
					res_d.tuning    = {note_semi, {mmnt_pkg::FracW{1'b0}}};
				end else if (kind_q inside {mmnt_pkg::KIND_NOTE_OFF, mmnt_pkg::KIND_NOTE_ON}) begin
					key_d = first_q;
					if (held_vld_q && held_key_q == first_q) begin
						held_vld_d   = 1'b0;
						res_d.action = mmnt_pkg::ACT_RELEASE;
					end
				end else if (kind_q == mmnt_pkg::KIND_CONTROL) begin
					if (first_q == mmnt_pkg::CcAllSoundOff || first_q == mmnt_pkg::CcAllNotesOff) begin
						held_vld_d   = 1'b0;
						res_d.action = mmnt_pkg::ACT_PANIC;
					end
				end else if (kind_q == mmnt_pkg::KIND_BEND) begin
					// (key - 39) semitones plus the raw 14-bit bend word
					res_d.action = mmnt_pkg::ACT_BEND;
					res_d.tuning = {bend_semi, {mmnt_pkg::FracW{1'b0}}}
						+ {{(mmnt_pkg::TuneW-2*mmnt_pkg::Data7W){1'b0}}, data7, first_q};
				end
			end
		endcase

		// End of block drops any partial message
		if (s_tlast) begin
			pos_d = mmnt_pkg::POS_STATUS;
		end

		res_d.velocity = vel_d;
		res_d.key      = key_d;
	end

	// Advance tracker state on each input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= mmnt_pkg::POS_STATUS;
			kind_q     <= '0;
			first_q    <= '0;
			key_q      <= '0;
			held_vld_q <= 1'b0;
			held_key_q <= '0;
			vel_q      <= '0;
		end else if (in_beat) begin
			pos_q      <= pos_d;
			kind_q     <= kind_d;
			first_q    <= first_d;
			key_q      <= key_d;
			held_vld_q <= held_vld_d;
			held_key_q <= held_key_d;
			vel_q      <= vel_d;
		end
	end

	// Output valid flags: result register backed by a skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!res_vld_q || out_beat) begin
				res_vld_q  <= skid_vld_q || in_beat;
				skid_vld_q <= 1'b0;
			end else if (in_beat) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// Output payload: hold when stalled, refill from skid first
	always_ff @(posedge clk) begin
		if (!res_vld_q || out_beat) begin
			res_q <= skid_vld_q ? skid_q : res_d;
		end
		if (in_beat && res_vld_q && !out_beat) begin
			skid_q <= res_d;
		end
	end

	assign m_tvalid = res_vld_q;
	assign m_tuser  = res_q.action;
	assign m_tdata  = {{(mmnt_pkg::MTdataW-1-mmnt_pkg::TuneW-2*mmnt_pkg::Data7W){1'b0}},
		res_q.key, res_q.velocity, res_q.tuning, res_q.retrigger};

endmodule

[test/tb_top.sv]
// Self-checking bench for the monophonic MIDI note tracker: byte stream in,
// result stream out, legato register over the APB port.
// Depends on mmnt_pkg and midi_mono_note_tracker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NOTE_BASE  = 38;
	localparam int SEMITONE   = 8192;
	localparam int BEND_MID   = 'h2000;
	localparam int IDLE_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mmnt_pkg::ByteW-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mmnt_pkg::MTdataW-1:0] m_tdata;
	logic [mmnt_pkg::ActW-1:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	midi_mono_note_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Tracker state as the bench sees it
	logic legato_cfg = 1'b0;
	mmnt_pkg::pos_t trk_pos = mmnt_pkg::POS_STATUS;
	logic [3:0] trk_kind = '0;
	logic [6:0] trk_first = '0;
	logic [6:0] trk_key = '0;
	logic trk_held = 1'b0;
	logic [6:0] trk_held_key = '0;
	logic [6:0] trk_vel = '0;

	mmnt_pkg::result_t tracker_results_due [$];
	mmnt_pkg::result_t mon_due;
	int error_count = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	int tx_calm = 0;
	int rx_hold = 0;
	int rx_calm = 0;

	// Advance the tracker by one byte and return the result it must give
	function automatic mmnt_pkg::result_t track_byte(logic [7:0] b, logic eob);
		mmnt_pkg::result_t r;
		logic [6:0] v;
		int t;
		r = '0;
		t = 0;
		v = b[6:0];
		r.action = mmnt_pkg::ACT_NONE;
		case (trk_pos)
			mmnt_pkg::POS_STATUS: begin
				if (b[7:4] != mmnt_pkg::KIND_SYSTEM) begin
					trk_kind = b[7:4];
					trk_pos = mmnt_pkg::POS_DATA1;
				end
			end
			mmnt_pkg::POS_DATA1: begin
				trk_first = v;
				trk_pos = (trk_kind == mmnt_pkg::KIND_PROGRAM ||
					trk_kind == mmnt_pkg::KIND_AFTERTOUCH) ?
					mmnt_pkg::POS_STATUS : mmnt_pkg::POS_DATA2;
			end
			default: begin
				trk_pos = mmnt_pkg::POS_STATUS;
				if (trk_kind == mmnt_pkg::KIND_NOTE_ON && v != 0) begin
					trk_key = trk_first;
					trk_vel = v;
					r.retrigger = !trk_held || !legato_cfg;
					t = (int'(trk_first) - NOTE_BASE) * SEMITONE;
					trk_held = 1'b1;
					trk_held_key = trk_first;
					r.action = mmnt_pkg::ACT_NOTE_ON;
				end else if (trk_kind == mmnt_pkg::KIND_NOTE_OFF ||
					trk_kind == mmnt_pkg::KIND_NOTE_ON) begin
					trk_key = trk_first;
					if (trk_held && trk_held_key == trk_first) begin
						trk_held = 1'b0;
						r.action = mmnt_pkg::ACT_RELEASE;
					end
				end else if (trk_kind == mmnt_pkg::KIND_CONTROL) begin
					if (trk_first == mmnt_pkg::CcAllSoundOff ||
						trk_first == mmnt_pkg::CcAllNotesOff) begin
						trk_held = 1'b0;
						r.action = mmnt_pkg::ACT_PANIC;
					end
				end else if (trk_kind == mmnt_pkg::KIND_BEND) begin
					t = (int'(trk_key) - NOTE_BASE) * SEMITONE
						+ int'(trk_first) + (int'(v) << 7) - BEND_MID;
					r.action = mmnt_pkg::ACT_BEND;
				end
			end
		endcase
		if (eob)
			trk_pos = mmnt_pkg::POS_STATUS;
		r.tuning = t[mmnt_pkg::TuneW-1:0];
		r.velocity = trk_vel;
		r.key = trk_key;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s at %0t: got %0h want %0h", field, $realtime, got, want);
		error_count++;
	endtask

	// Predict on each accepted byte beat, check each accepted result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker_results_due.push_back(track_byte(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				if (tracker_results_due.size() == 0) begin
					report_mismatch("unexpected beat", {m_tuser, m_tdata[28:0]}, '0);
				end else begin
					mon_due = tracker_results_due.pop_front();
					if (m_tuser !== mon_due.action)
						report_mismatch("action", 32'(m_tuser), 32'(mon_due.action));
					if (m_tdata[0] !== mon_due.retrigger)
						report_mismatch("retrigger", 32'(m_tdata[0]),
							32'(mon_due.retrigger));
					if (m_tdata[21:1] !== mon_due.tuning)
						report_mismatch("tuning", 32'(m_tdata[21:1]), 32'(mon_due.tuning));
					if (m_tdata[28:22] !== mon_due.velocity)
						report_mismatch("velocity", 32'(m_tdata[28:22]),
							32'(mon_due.velocity));
					if (m_tdata[35:29] !== mon_due.key)
						report_mismatch("key", 32'(m_tdata[35:29]), 32'(mon_due.key));
					if (m_tdata[39:36] !== 4'b0)
						report_mismatch("pad", 32'(m_tdata[39:36]), '0);
				end
			end
		end
	end

	// Drive receiver back-pressure: mostly open, short and long stalls, calm stretches
	always @(posedge clk) begin
		if (rx_calm > 0) begin
			rx_calm--;
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					rx_hold = $urandom_range(0, 2);
					m_tready <= 1'b0;
				end
				4: begin
					rx_hold = $urandom_range(7, 39);
					m_tready <= 1'b0;
				end
				5: begin
					rx_calm = $urandom_range(50, 200);
					m_tready <= 1'b1;
				end
				default: m_tready <= 1'b1;
			endcase
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(6, 40);
		tx_calm = $urandom_range(40, 150);
		return 0;
	endfunction

	// Offer one byte beat and hold it until accepted; valid stays high afterwards
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Hold the sender until every predicted result has come back
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic read_legato_check();
		logic got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'(mmnt_pkg::REG_LEGATO) << 2;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata[0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== legato_cfg)
			report_mismatch("legato readback", 32'(got), 32'(legato_cfg));
	endtask

	// Write legato while idle, with readback before and after
	task automatic set_legato(logic value);
		read_legato_check();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(mmnt_pkg::REG_LEGATO) << 2;
		pwdata <= {16'($urandom_range(0, 'h7FFF)), 16'($urandom_range(0, 'hFFFF)) & 16'hFFFE}
			| 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		legato_cfg = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		read_legato_check();
	endtask

	task automatic test_register_access();
		set_legato(1'b1);
		set_legato(1'b0);
	endtask

	// Field extremes, every message kind and the parser corner cases
	task automatic test_message_corners();
		logic [8:0] seq [$];
		// note-off with nothing held, then bend at key 0 (lowest tuning)
		// note-on at key 127, bend to the top (highest tuning)
		// retrigger while held, note-off of another key, velocity zero release
		seq = '{9'h080, 9'h000, 9'h000, 9'h0E0, 9'h000, 9'h000,
			9'h09F, 9'h07F, 9'h07F, 9'h0EA, 9'h07F, 9'h07F,
			9'h095, 9'h000, 9'h001, 9'h080, 9'h07F, 9'h040, 9'h090, 9'h000, 9'h000,
			// panic on both controllers, a plain controller, one-byte kinds
			9'h091, 9'h040, 9'h064, 9'h0B0, 9'h078, 9'h000, 9'h0B3, 9'h07B, 9'h07F,
			9'h0B0, 9'h007, 9'h07F, 9'h0C0, 9'h005, 9'h0D0, 9'h07F,
			// system bytes skipped, data byte and poly aftertouch as status
			9'h0F8, 9'h0FF, 9'h045, 9'h010, 9'h020, 9'h0A0, 9'h010, 9'h020,
			// status bytes in data position, then a note cut short by end of block
			9'h090, 9'h081, 9'h0C0, 9'h090, 9'h13C, 9'h140, 9'h080, 9'h001, 9'h000};
		foreach (seq[i])
			send_byte(seq[i][7:0], seq[i][8]);
		wait_results_done();
		set_legato(1'b1);
		// legato: second note while held must not retrigger, then release it
		seq = '{9'h090, 9'h030, 9'h050, 9'h090, 9'h032, 9'h011, 9'h080, 9'h032, 9'h000,
			9'h090, 9'h033, 9'h022};
		foreach (seq[i])
			send_byte(seq[i][7:0], seq[i][8]);
		wait_results_done();
	endtask

	function automatic logic [7:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(60, 63));
		return 8'($urandom_range(0, 127));
	endfunction

	// Mostly well-formed messages with random content, some noise and broken ones
	task automatic send_random_message();
		logic [7:0] msg [3];
		logic [3:0] ch;
		int len;
		int roll;
		int cut;
		ch = 4'($urandom_range(0, 15));
		msg[1] = pick_key();
		msg[2] = 8'($urandom_range(1, 127));
		len = 3;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			msg[0] = {mmnt_pkg::KIND_NOTE_ON, ch};
			if ($urandom_range(0, 9) == 0)
				msg[2] = 8'h00;
		end else if (roll < 55) begin
			msg[0] = {mmnt_pkg::KIND_NOTE_OFF, ch};
			msg[2] = 8'($urandom_range(0, 127));
		end else if (roll < 65) begin
			msg[0] = {mmnt_pkg::KIND_CONTROL, ch};
			case ($urandom_range(0, 3))
				0: msg[1] = {1'b0, mmnt_pkg::CcAllSoundOff};
				1: msg[1] = {1'b0, mmnt_pkg::CcAllNotesOff};
				default: msg[1] = 8'($urandom_range(0, 127));
			endcase
		end else if (roll < 75) begin
			msg[0] = {mmnt_pkg::KIND_BEND, ch};
			msg[1] = 8'($urandom_range(0, 127));
			msg[2] = 8'($urandom_range(0, 127));
		end else if (roll < 83) begin
			msg[0] = {($urandom_range(0, 1) != 0) ? mmnt_pkg::KIND_PROGRAM :
				mmnt_pkg::KIND_AFTERTOUCH, ch};
			len = 2;
		end else if (roll < 87) begin
			msg[0] = {mmnt_pkg::KIND_SYSTEM, ch};
			len = 1;
		end else if (roll < 92) begin
			msg[0] = {($urandom_range(0, 3) == 0) ? mmnt_pkg::KIND_POLY_TOUCH :
				4'($urandom_range(0, 7)), ch};
		end else begin
			msg[0] = 8'($urandom_range(0, 255));
			len = 1;
		end
		// Status byte in data position now and then
		if ($urandom_range(0, 19) == 0)
			msg[1][7] = 1'b1;
		if ($urandom_range(0, 19) == 0)
			msg[2][7] = 1'b1;
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
		for (int i = 0; i < len && i <= cut; i++)
			send_byte(msg[i], (i == cut) || (i == len - 1 && $urandom_range(0, 9) == 0));
	endtask

	task automatic test_random_traffic(logic legato, int count);
		int stop_at;
		int pause_at;
		set_legato(legato);
		stop_at = bytes_sent + count;
		pause_at = bytes_sent + count / 2;
		while (bytes_sent < stop_at) begin
			send_random_message();
			if (pause_at > 0 && bytes_sent >= pause_at) begin
				wait_results_done();
				pause_at = 0;
			end
		end
		wait_results_done();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_message_corners();
		test_random_traffic(1'b0, 350);
		test_random_traffic(1'b1, 450);
		test_random_traffic(1'($urandom_range(0, 1)), 250);
		test_random_traffic(1'b0, 150);
		// Let any stray beat show up before judging
		repeat (8) @(posedge clk);
		if (error_count == 0 && tracker_results_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
